// ===== src/tpb_pkg.sv =====
`default_nettype none
package tpb_pkg;

	// geometry
	localparam int COORD_BITS    = 11;
	localparam int CHECKER_SHIFT = 4;
	localparam int DW            = COORD_BITS + 3;  // signed working width for box math
	localparam int BOX_W         = COORD_BITS + 1;  // signed box corner width

	// field widths
	localparam int CMD_W   = 2;
	localparam int KEY_W   = 3;
	localparam int COLOR_W = 8;
	localparam int SIZE_W  = 8;
	localparam int STEP_W  = 8;
	localparam int BORD_W  = 4;

	// ramp divider: quotient is below 256 because pos < frame size
	localparam int QW    = 8;
	localparam int NUM_W = COORD_BITS + QW;

	// config port
	localparam int NUM_REGS = 5;
	localparam int PADDR_W  = $clog2(4 * NUM_REGS);
	localparam int IDX_W    = PADDR_W - 2;
	localparam int PDATA_W  = 32;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_BOX_SIDE     = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_MOVE_STEP    = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_BORDER_WIDTH = IDX_W'(4);

	// reset values
	localparam int FW_RST   = 640;
	localparam int FH_RST   = 480;
	localparam int SIZE_RST = 48;
	localparam int STEP_RST = 8;
	localparam int BORD_RST = 2;
	localparam int LEFT_RST = FW_RST / 2 - SIZE_RST / 2;
	localparam int TOP_RST  = FH_RST / 2 - SIZE_RST / 2;

	// command and key codes
	localparam logic [CMD_W-1:0] CMD_PIXEL  = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_KEY    = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_MOUSE  = CMD_W'(2);
	localparam logic [CMD_W-1:0] CMD_CENTRE = CMD_W'(3);

	localparam logic [KEY_W-1:0] KEY_LEFT  = KEY_W'(0);
	localparam logic [KEY_W-1:0] KEY_RIGHT = KEY_W'(1);
	localparam logic [KEY_W-1:0] KEY_UP    = KEY_W'(2);
	localparam logic [KEY_W-1:0] KEY_DOWN  = KEY_W'(3);
	localparam logic [KEY_W-1:0] KEY_ESC   = KEY_W'(4);
	localparam logic [KEY_W-1:0] KEY_Q     = KEY_W'(5);

	// colors
	localparam logic [COLOR_W-1:0] WHITE    = 8'hFF;
	localparam logic [COLOR_W-1:0] BOX_FILL = 8'h0B;

	// saturation bounds
	localparam logic signed [DW-1:0] CRD_HI = DW'((1 << COORD_BITS) - 1);
	localparam logic signed [DW-1:0] CRD_LO = DW'(-(1 << COORD_BITS));

	// work classes handed from front to back
	typedef enum logic [2:0] {
		OP_BLANK,
		OP_PIXEL,
		OP_LEFT,
		OP_RIGHT,
		OP_UP,
		OP_DOWN,
		OP_QUIT,
		OP_CENTRE
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} qent_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] frame_width;
		logic [COORD_BITS-1:0] frame_height;
		logic [SIZE_W-1:0]     box_side;
		logic [STEP_W-1:0]     move_step;
		logic [BORD_W-1:0]     border_width;
	} cfg_t;

	function automatic logic signed [BOX_W-1:0] sat_coord(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] c;
		c = v;
		if (v > CRD_HI) c = CRD_HI;
		if (v < CRD_LO) c = CRD_LO;
		return c[BOX_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== src/tpb_if.sv =====
`default_nettype none
interface tpb_req_if;
	logic                              valid;
	logic                              ready;
	logic [tpb_pkg::CMD_W-1:0]         cmd;
	logic [tpb_pkg::COORD_BITS-1:0]    pos_x;
	logic [tpb_pkg::COORD_BITS-1:0]    pos_y;
	logic [tpb_pkg::KEY_W-1:0]         key_code;

	modport source (output valid, cmd, pos_x, pos_y, key_code, input ready);
	modport sink   (input valid, cmd, pos_x, pos_y, key_code, output ready);
endinterface

interface tpb_res_if;
	logic                        valid;
	logic                        ready;
	logic [tpb_pkg::COLOR_W-1:0] color;
	logic                        pixel_valid;
	logic                        quit;

	modport source (output valid, color, pixel_valid, quit, input ready);
	modport sink   (input valid, color, pixel_valid, quit, output ready);
endinterface
`default_nettype wire

// ===== src/tpb_front.sv =====
`default_nettype none
// Decodes a request into a work class for the back end.
module tpb_front (
	input  tpb_pkg::cfg_t  cfg,
	tpb_req_if.sink        req,
	input  logic           q_full,
	output logic           push,
	output tpb_pkg::qent_t ent
);
	assign req.ready = !q_full;
	assign push      = req.valid && !q_full;

	always_comb begin
		ent.op = tpb_pkg::OP_BLANK;
		ent.x  = req.pos_x;
		ent.y  = req.pos_y;
		unique case (req.cmd)
			tpb_pkg::CMD_PIXEL: begin
				// zero frame size fails the compare on its own
				if (req.pos_x < cfg.frame_width && req.pos_y < cfg.frame_height)
					ent.op = tpb_pkg::OP_PIXEL;
			end
			tpb_pkg::CMD_KEY: begin
				case (req.key_code) inside
					tpb_pkg::KEY_LEFT:             ent.op = tpb_pkg::OP_LEFT;
					tpb_pkg::KEY_RIGHT:            ent.op = tpb_pkg::OP_RIGHT;
					tpb_pkg::KEY_UP:               ent.op = tpb_pkg::OP_UP;
					tpb_pkg::KEY_DOWN:             ent.op = tpb_pkg::OP_DOWN;
					tpb_pkg::KEY_ESC, tpb_pkg::KEY_Q: ent.op = tpb_pkg::OP_QUIT;
					default:                       ent.op = tpb_pkg::OP_BLANK;
				endcase
			end
			tpb_pkg::CMD_MOUSE: begin
				ent.op = tpb_pkg::OP_CENTRE;
			end
			tpb_pkg::CMD_CENTRE: begin
				ent.op = tpb_pkg::OP_CENTRE;
				ent.x  = cfg.frame_width >> 1;
				ent.y  = cfg.frame_height >> 1;
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== src/tpb_queue.sv =====
`default_nettype none
// Two-entry FIFO between front and back.
module tpb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tpb_pkg::qent_t wr_ent,
	output logic           full,
	input  logic           pop,
	output logic           rd_valid,
	output tpb_pkg::qent_t rd_ent
);
	tpb_pkg::qent_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;

	assign full     = cnt_q == 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_ent   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_ent;
	end
endmodule
`default_nettype wire

// ===== src/tpb_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
// Caller guarantees num < den * 2^QW.
module tpb_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tpb_pkg::NUM_W-1:0]         num,
	input  logic [tpb_pkg::COORD_BITS-1:0]    den,
	output logic [tpb_pkg::QW-1:0]            quo,
	output logic                              done
);
	localparam int CNT_W = $clog2(tpb_pkg::QW);

	logic [tpb_pkg::NUM_W-1:0] rem_q;
	logic [tpb_pkg::NUM_W-1:0] dsh_q;
	logic [tpb_pkg::QW-1:0]    quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic                      ge;

	assign ge   = rem_q >= dsh_q;
	assign quo  = quo_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(tpb_pkg::QW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= tpb_pkg::NUM_W'(den) << (tpb_pkg::QW - 1);
		end else if (busy_q) begin
			if (ge) rem_q <= rem_q - dsh_q;
			quo_q <= {quo_q[tpb_pkg::QW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end
endmodule
`default_nettype wire

// ===== src/tpb_back.sv =====
`default_nettype none
// Executes queued work: box moves, pixel shading, result register.
module tpb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  tpb_pkg::cfg_t  cfg,
	input  logic           q_valid,
	input  tpb_pkg::qent_t q_ent,
	output logic           pop,
	tpb_res_if.source      res
);
	localparam int CB = tpb_pkg::COORD_BITS;
	localparam int DW = tpb_pkg::DW;

	typedef enum logic {S_IDLE, S_DIV} state_t;

	state_t                           state_q;
	logic signed [tpb_pkg::BOX_W-1:0] box_left_q;
	logic signed [tpb_pkg::BOX_W-1:0] box_top_q;
	logic [CB-1:0]                    px_q;
	logic [CB-1:0]                    py_q;
	logic                             res_valid_q;
	logic [tpb_pkg::COLOR_W-1:0]      color_q;
	logic                             pix_valid_q;
	logic                             quit_q;

	logic                        out_free;
	logic                        div_start;
	logic                        res_cmd;
	logic                        res_pix;
	logic                        res_load;
	logic [tpb_pkg::QW-1:0]      quo_r;
	logic [tpb_pkg::QW-1:0]      quo_g;
	logic                        done_r;
	logic                        done_g;
	logic                        div_done;
	logic signed [DW-1:0]        left_s;
	logic signed [DW-1:0]        top_s;
	logic signed [DW-1:0]        step_s;
	logic signed [DW-1:0]        half_s;
	logic signed [DW-1:0]        dx;
	logic signed [DW-1:0]        dy;
	logic signed [DW-1:0]        bw_s;
	logic signed [DW-1:0]        sz_s;
	logic                        in_frame_x;
	logic                        in_frame_y;
	logic                        in_box_x;
	logic                        in_box_y;
	logic                        chk;
	logic [tpb_pkg::COLOR_W-1:0] pix_color;

	assign out_free  = !res_valid_q || res.ready;
	assign pop       = (state_q == S_IDLE) && q_valid &&
	                   (q_ent.op == tpb_pkg::OP_PIXEL || out_free);
	assign div_start = pop && q_ent.op == tpb_pkg::OP_PIXEL;
	assign div_done  = done_r && done_g;

	// result loads: non-pixel request at pop, pixel once divided and output free
	assign res_cmd  = (state_q == S_IDLE) && pop && q_ent.op != tpb_pkg::OP_PIXEL;
	assign res_pix  = (state_q == S_DIV) && div_done && out_free;
	assign res_load = res_cmd || res_pix;

	// x*255 as (x << 8) - x
	tpb_div u_div_r (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({q_ent.x, 8'b0} - tpb_pkg::NUM_W'(q_ent.x)),
		.den(cfg.frame_width), .quo(quo_r), .done(done_r)
	);
	tpb_div u_div_g (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({q_ent.y, 8'b0} - tpb_pkg::NUM_W'(q_ent.y)),
		.den(cfg.frame_height), .quo(quo_g), .done(done_g)
	);

	assign left_s = {{(DW-tpb_pkg::BOX_W){box_left_q[tpb_pkg::BOX_W-1]}}, box_left_q};
	assign top_s  = {{(DW-tpb_pkg::BOX_W){box_top_q[tpb_pkg::BOX_W-1]}}, box_top_q};
	assign step_s = $signed({{(DW-tpb_pkg::STEP_W){1'b0}}, cfg.move_step});
	assign half_s = $signed({{(DW-tpb_pkg::SIZE_W+1){1'b0}}, cfg.box_side[tpb_pkg::SIZE_W-1:1]});
	assign bw_s   = $signed({{(DW-tpb_pkg::BORD_W){1'b0}}, cfg.border_width});
	assign sz_s   = $signed({{(DW-tpb_pkg::SIZE_W){1'b0}}, cfg.box_side});

	// pixel offset from box corner; border spans [-bw, sz+bw), fill spans [0, sz)
	assign dx = $signed({{(DW-CB){1'b0}}, px_q}) - left_s;
	assign dy = $signed({{(DW-CB){1'b0}}, py_q}) - top_s;
	assign in_frame_x = (dx >= -bw_s) && (dx < sz_s + bw_s);
	assign in_frame_y = (dy >= -bw_s) && (dy < sz_s + bw_s);
	assign in_box_x   = !dx[DW-1] && (dx < sz_s);
	assign in_box_y   = !dy[DW-1] && (dy < sz_s);
	assign chk        = px_q[tpb_pkg::CHECKER_SHIFT] ^ py_q[tpb_pkg::CHECKER_SHIFT];

	always_comb begin
		pix_color = {quo_r[7:5], quo_g[7:5], chk, chk};
		if (in_frame_x && in_frame_y) pix_color = tpb_pkg::WHITE;
		if (in_box_x && in_box_y)     pix_color = tpb_pkg::BOX_FILL;
	end

	assign res.valid       = res_valid_q;
	assign res.color       = color_q;
	assign res.pixel_valid = pix_valid_q;
	assign res.quit        = quit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			color_q     <= '0;
			pix_valid_q <= 1'b0;
			quit_q      <= 1'b0;
			box_left_q  <= tpb_pkg::BOX_W'(tpb_pkg::LEFT_RST);
			box_top_q   <= tpb_pkg::BOX_W'(tpb_pkg::TOP_RST);
		end else begin
			if (res_load)       res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
			if (res_pix) begin
				color_q     <= pix_color;
				pix_valid_q <= 1'b1;
				quit_q      <= 1'b0;
			end else if (res_cmd) begin
				color_q     <= '0;
				pix_valid_q <= 1'b0;
				quit_q      <= q_ent.op == tpb_pkg::OP_QUIT;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (q_ent.op == tpb_pkg::OP_PIXEL) begin
							state_q <= S_DIV;
						end else begin
							case (q_ent.op)
								tpb_pkg::OP_LEFT:
									box_left_q <= tpb_pkg::sat_coord(left_s - step_s);
								tpb_pkg::OP_RIGHT:
									box_left_q <= tpb_pkg::sat_coord(left_s + step_s);
								tpb_pkg::OP_UP:
									box_top_q <= tpb_pkg::sat_coord(top_s - step_s);
								tpb_pkg::OP_DOWN:
									box_top_q <= tpb_pkg::sat_coord(top_s + step_s);
								tpb_pkg::OP_CENTRE: begin
									box_left_q <= tpb_pkg::sat_coord(
										$signed({{(DW-CB){1'b0}}, q_ent.x}) - half_s);
									box_top_q <= tpb_pkg::sat_coord(
										$signed({{(DW-CB){1'b0}}, q_ent.y}) - half_s);
								end
								default: ;
							endcase
						end
					end
				end
				S_DIV: begin
					if (res_pix) state_q <= S_IDLE;
				end
			endcase
		end
	end

	// pixel coordinates held for shading
	always_ff @(posedge clk) begin
		if (div_start) begin
			px_q <= q_ent.x;
			py_q <= q_ent.y;
		end
	end
endmodule
`default_nettype wire

// ===== src/test_pattern_with_moving_box_top.sv =====
`default_nettype none
// Channel   Dir  Handshake             Payload
// pix_in    in   valid/ready           cmd, pos_x, pos_y, key_code
// pix_out   out  valid/ready           color, pixel_valid, quit
// apb       in   psel/penable, pready  paddr, pwdata (write), prdata (read)
//
// Pixel request inside the frame: the result waits on the 8-step shift-subtract
// dividers for the red and green ramps (run side by side); the back end takes no
// new request from the queue until the last pixel's result is loaded.
// Key, mouse, recentre and out-of-frame requests: the result is registered after
// the queue; one request per cycle sustained while the result side keeps up.
// Reset: asynchronous, active low; config returns to 640x480, box 48, step 8,
// border 2, box corner at (296, 216). No clearing pass.
// Stalls: a 2-deep queue decouples accept from execution; the result register
// holds while pix_out.ready is low and the next request waits in the queue.
module test_pattern_with_moving_box_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tpb_pkg::PADDR_W-1:0]   paddr,
	input  logic [tpb_pkg::PDATA_W-1:0]   pwdata,
	output logic [tpb_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	tpb_req_if.sink                       pix_in,
	tpb_res_if.source                     pix_out
);
	tpb_pkg::cfg_t               cfg_q;
	logic [tpb_pkg::IDX_W-1:0]   idx;
	logic                        cfg_wr;
	logic                        push;
	logic                        q_full;
	logic                        q_valid;
	logic                        pop;
	tpb_pkg::qent_t              wr_ent;
	tpb_pkg::qent_t              rd_ent;

	// APB: zero wait states, byte address 4*i picks register i
	assign pready = 1'b1;
	assign idx    = paddr[tpb_pkg::PADDR_W-1:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= tpb_pkg::COORD_BITS'(tpb_pkg::FW_RST);
			cfg_q.frame_height <= tpb_pkg::COORD_BITS'(tpb_pkg::FH_RST);
			cfg_q.box_side     <= tpb_pkg::SIZE_W'(tpb_pkg::SIZE_RST);
			cfg_q.move_step    <= tpb_pkg::STEP_W'(tpb_pkg::STEP_RST);
			cfg_q.border_width <= tpb_pkg::BORD_W'(tpb_pkg::BORD_RST);
		end else if (cfg_wr) begin
			// addresses past the last register are ignored
			case (idx)
				tpb_pkg::REG_FRAME_WIDTH:
					cfg_q.frame_width  <= pwdata[tpb_pkg::COORD_BITS-1:0];
				tpb_pkg::REG_FRAME_HEIGHT:
					cfg_q.frame_height <= pwdata[tpb_pkg::COORD_BITS-1:0];
				tpb_pkg::REG_BOX_SIDE:
					cfg_q.box_side     <= pwdata[tpb_pkg::SIZE_W-1:0];
				tpb_pkg::REG_MOVE_STEP:
					cfg_q.move_step    <= pwdata[tpb_pkg::STEP_W-1:0];
				tpb_pkg::REG_BORDER_WIDTH:
					cfg_q.border_width <= pwdata[tpb_pkg::BORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			tpb_pkg::REG_FRAME_WIDTH:  prdata = tpb_pkg::PDATA_W'(cfg_q.frame_width);
			tpb_pkg::REG_FRAME_HEIGHT: prdata = tpb_pkg::PDATA_W'(cfg_q.frame_height);
			tpb_pkg::REG_BOX_SIDE:     prdata = tpb_pkg::PDATA_W'(cfg_q.box_side);
			tpb_pkg::REG_MOVE_STEP:    prdata = tpb_pkg::PDATA_W'(cfg_q.move_step);
			tpb_pkg::REG_BORDER_WIDTH: prdata = tpb_pkg::PDATA_W'(cfg_q.border_width);
			default:                   prdata = '0;
		endcase
	end

	// front: decode each request into a work class
	tpb_front u_front (
		.cfg(cfg_q), .req(pix_in), .q_full(q_full), .push(push), .ent(wr_ent)
	);

	// queue: lets the front keep accepting while the back divides
	tpb_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_ent(wr_ent), .full(q_full),
		.pop(pop), .rd_valid(q_valid), .rd_ent(rd_ent)
	);

	// back: box state, ramp dividers, shading and the result register
	tpb_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(q_valid), .q_ent(rd_ent),
		.pop(pop), .res(pix_out)
	);
endmodule
`default_nettype wire

// ===== src/tpb_checker.sv =====
`default_nettype none
module tpb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [tpb_pkg::COLOR_W-1:0] res_color,
	input logic                        res_pixel_valid,
	input logic                        res_quit,
	input logic                        pready
);
	// stalled result stays up
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_color) &&
		$stable(res_pixel_valid) && $stable(res_quit))
		else $error("result dropped or changed while stalled");

	// non-pixel or out-of-frame results carry no color
	a_blank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_pixel_valid |-> res_color == '0)
		else $error("color set on a result without a valid pixel");

	// a shaded pixel never reports quit
	a_quit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_quit && res_pixel_valid))
		else $error("quit and pixel_valid both set");

	// zero-wait config port
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind test_pattern_with_moving_box_top tpb_checker u_tpb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(pix_out.valid),
	.res_ready(pix_out.ready),
	.res_color(pix_out.color),
	.res_pixel_valid(pix_out.pixel_valid),
	.res_quit(pix_out.quit),
	.pready(pready)
);
`default_nettype wire
